// ===== rtl/core/pdfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfr_pkg
// Types, codes and constants shared by the port demux frame receiver.
// ----------------------------------------------------------------------------
package pdfr_pkg;

    localparam int PORTS_DEFAULT = 256;
    localparam int Q_DEPTH       = 2;

    localparam logic [7:0] HEADER_BYTE = 8'h5A;

    // command codes
    localparam logic [1:0] CMD_STREAM   = 2'd0;
    localparam logic [1:0] CMD_REG_AT   = 2'd1;
    localparam logic [1:0] CMD_REG_FREE = 2'd2;
    localparam logic [1:0] CMD_RELEASE  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_OCCUPIED = 2'd1;
    localparam logic [1:0] STS_IDLE     = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    // frame parser phases
    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_PORT     = 3'd1;
    localparam logic [2:0] PH_LEN      = 3'd2;
    localparam logic [2:0] PH_LEN_SKIP = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;
    localparam logic [2:0] PH_SKIP     = 3'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [7:0] port;
        logic [7:0] capacity;
        logic       one_shot;
    } item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [1:0] status;
        logic [7:0] port_out;
        logic [7:0] offset;
        logic [7:0] payload_byte;
        logic [7:0] message_length;
        logic       last;
    } result_t;

    // queue entry: the transaction plus what the front end worked out
    typedef struct packed {
        item_t item;
        logic  port_ok;
        logic  data_ok;
        logic  is_header;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t entry;
    } q_head_t;

endpackage

// ===== rtl/core/pdfr_front.sv =====
// ----------------------------------------------------------------------------
// pdfr_front
// Input acceptance, classification and a short transaction queue.
// ----------------------------------------------------------------------------
module pdfr_front
    import pdfr_pkg::*;
#(
    parameter int PORTS = PORTS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    input  logic    pop,
    output q_head_t head
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    q_item_t          q_mem [Q_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic             push;
    q_item_t          classified;

    assign item_stall = (cnt_reg == QCW'(Q_DEPTH));
    assign push       = item_valid && !item_stall;

    always_comb
    begin
        classified.item      = item;
        classified.port_ok   = ({1'b0, item.port} < 9'(PORTS));
        classified.data_ok   = ({1'b0, item.data_byte} < 9'(PORTS));
        classified.is_header = (item.data_byte == HEADER_BYTE);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= classified;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.entry = q_mem[rd_ptr_reg];

endmodule

// ===== rtl/core/pdfr_back.sv =====
// ----------------------------------------------------------------------------
// pdfr_back
// Frame parser, listener table and free-port search, with output register.
// ----------------------------------------------------------------------------
module pdfr_back
    import pdfr_pkg::*;
#(
    parameter int PORTS = PORTS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_head_t head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int CW = $clog2(PORTS + 1);

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_READ = 2'd1;
    localparam logic [1:0] ENG_SCAN = 2'd2;

    // table: valid marks in flops, one_shot and capacity in memory
    logic [8:0]       mem [PORTS];
    logic [8:0]       mem_rd_reg;
    logic             mem_we, mem_re;
    logic [PW-1:0]    mem_wa, mem_ra;
    logic [8:0]       mem_wd;

    logic [PORTS-1:0] valid_reg, valid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [1:0]       eng_reg, eng_next;
    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       frame_port_reg, frame_port_next;
    logic [7:0]       frame_cap_reg, frame_cap_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       offset_reg, offset_next;
    logic [PW-1:0]    alloc_reg, alloc_next;
    logic [PW-1:0]    scan_reg, scan_next;

    logic             out_valid_reg;
    result_t          out_reg;
    logic             out_can, out_load;
    result_t          out_item;

    item_t            it;
    logic [PW-1:0]    idx_port, idx_data, idx_frame;
    logic [7:0]       b;

    assign out_can   = !out_valid_reg || !result_stall;
    assign it        = head.entry.item;
    assign b         = it.data_byte;
    assign idx_port  = it.port[PW-1:0];
    assign idx_data  = it.data_byte[PW-1:0];
    assign idx_frame = frame_port_reg[PW-1:0];

    always_comb
    begin
        eng_next        = eng_reg;
        phase_next      = phase_reg;
        frame_port_next = frame_port_reg;
        frame_cap_next  = frame_cap_reg;
        left_next       = left_reg;
        offset_next     = offset_reg;
        alloc_next      = alloc_reg;
        scan_next       = scan_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = idx_port;
        mem_wd          = {it.one_shot, it.capacity};
        mem_re          = 1'b0;
        mem_ra          = idx_data;
        out_load        = 1'b0;
        out_item        = '0;

        unique case (eng_reg)
            ENG_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (it.command)
                        CMD_STREAM:
                        begin
                            unique case (phase_reg)
                                PH_PORT:
                                begin
                                    frame_port_next = b;
                                    if (head.entry.data_ok && valid_reg[idx_data])
                                    begin
                                        mem_re   = 1'b1;
                                        eng_next = ENG_READ;
                                    end
                                    else
                                    begin
                                        phase_next = PH_LEN_SKIP;
                                        pop        = 1'b1;
                                    end
                                end
                                PH_LEN:
                                begin
                                    if (b == 8'd0 || b > frame_cap_reg)
                                    begin
                                        if (out_can)
                                        begin
                                            out_load                = 1'b1;
                                            out_item.result_kind    = KIND_DONE;
                                            out_item.port_out       = frame_port_reg;
                                            out_item.message_length = b;
                                            phase_next              = PH_HUNT;
                                            pop                     = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        left_next   = b;
                                        offset_next = 8'd0;
                                        phase_next  = PH_PAYLOAD;
                                        pop         = 1'b1;
                                    end
                                end
                                PH_LEN_SKIP:
                                begin
                                    left_next  = b;
                                    phase_next = (b == 8'd0) ? PH_HUNT : PH_SKIP;
                                    pop        = 1'b1;
                                end
                                PH_PAYLOAD:
                                begin
                                    if (out_can)
                                    begin
                                        out_load                = 1'b1;
                                        out_item.result_kind    = KIND_PAYLOAD;
                                        out_item.port_out       = frame_port_reg;
                                        out_item.offset         = offset_reg;
                                        out_item.payload_byte   = b;
                                        out_item.message_length = offset_reg + left_reg;
                                        out_item.last           = (left_reg <= 8'd1);
                                        offset_next             = offset_reg + 8'd1;
                                        left_next               = left_reg - 8'd1;
                                        if (left_reg == 8'd1)
                                        begin
                                            phase_next = PH_HUNT;
                                        end
                                        pop = 1'b1;
                                    end
                                end
                                PH_SKIP:
                                begin
                                    left_next = left_reg - 8'd1;
                                    if (left_reg == 8'd1)
                                    begin
                                        phase_next = PH_HUNT;
                                    end
                                    pop = 1'b1;
                                end
                                default:
                                begin
                                    phase_next = head.entry.is_header ? PH_PORT : PH_HUNT;
                                    pop        = 1'b1;
                                end
                            endcase
                        end
                        CMD_REG_AT:
                        begin
                            if (out_can)
                            begin
                                out_load             = 1'b1;
                                out_item.result_kind = KIND_STATUS;
                                out_item.port_out    = it.port;
                                pop                  = 1'b1;
                                if (!head.entry.port_ok)
                                begin
                                    out_item.status = STS_FULL;
                                end
                                else if (valid_reg[idx_port])
                                begin
                                    out_item.status = STS_OCCUPIED;
                                end
                                else
                                begin
                                    out_item.status      = STS_OK;
                                    mem_we               = 1'b1;
                                    valid_next[idx_port] = 1'b1;
                                    cnt_next             = cnt_reg + CW'(1);
                                end
                            end
                        end
                        CMD_REG_FREE:
                        begin
                            if (cnt_reg == CW'(PORTS))
                            begin
                                if (out_can)
                                begin
                                    out_load             = 1'b1;
                                    out_item.result_kind = KIND_STATUS;
                                    out_item.status      = STS_FULL;
                                    out_item.port_out    = 8'(alloc_reg);
                                    pop                  = 1'b1;
                                end
                            end
                            else
                            begin
                                scan_next = alloc_reg;
                                eng_next  = ENG_SCAN;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            if (out_can)
                            begin
                                out_load             = 1'b1;
                                out_item.result_kind = KIND_STATUS;
                                out_item.port_out    = it.port;
                                pop                  = 1'b1;
                                if (head.entry.port_ok && valid_reg[idx_port])
                                begin
                                    out_item.status      = STS_OK;
                                    valid_next[idx_port] = 1'b0;
                                    cnt_next             = cnt_reg - CW'(1);
                                end
                                else
                                begin
                                    out_item.status = STS_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
            ENG_READ:
            begin
                // listener entry for the port byte is now in mem_rd_reg
                frame_cap_next = mem_rd_reg[7:0];
                if (mem_rd_reg[8])
                begin
                    valid_next[idx_frame] = 1'b0;
                    cnt_next              = cnt_reg - CW'(1);
                end
                phase_next = PH_LEN;
                pop        = 1'b1;
                eng_next   = ENG_IDLE;
            end
            ENG_SCAN:
            begin
                // a free entry exists, so the walk always ends
                if (!valid_reg[scan_reg])
                begin
                    if (out_can)
                    begin
                        mem_we               = 1'b1;
                        mem_wa               = scan_reg;
                        valid_next[scan_reg] = 1'b1;
                        cnt_next             = cnt_reg + CW'(1);
                        alloc_next           = scan_reg;
                        out_load             = 1'b1;
                        out_item.result_kind = KIND_STATUS;
                        out_item.status      = STS_OK;
                        out_item.port_out    = 8'(scan_reg);
                        pop                  = 1'b1;
                        eng_next             = ENG_IDLE;
                    end
                end
                else
                begin
                    scan_next = (scan_reg == PW'(PORTS - 1)) ? '0 : scan_reg + PW'(1);
                end
            end
            default:
            begin
                eng_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg        <= ENG_IDLE;
            phase_reg      <= PH_HUNT;
            frame_port_reg <= '0;
            frame_cap_reg  <= '0;
            left_reg       <= '0;
            offset_reg     <= '0;
            alloc_reg      <= '0;
            scan_reg       <= '0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            eng_reg        <= eng_next;
            phase_reg      <= phase_next;
            frame_port_reg <= frame_port_next;
            frame_cap_reg  <= frame_cap_next;
            left_reg       <= left_next;
            offset_reg     <= offset_next;
            alloc_reg      <= alloc_next;
            scan_reg       <= scan_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[mem_ra];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/core/port_demux_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// port_demux_frame_receiver_core
// Serial frame receiver that routes payloads to registered port listeners.
// ----------------------------------------------------------------------------
// Input channel item/item_valid/item_stall carries stream bytes and table
// commands; output channel result/result_valid/result_stall carries command
// status, payload bytes and length-only reports. One transaction per handshake
// on each side, at most one result per input transaction.
// Inputs land in a two-entry queue; the back end takes one at a time.
// The port byte of a frame to a listened port waits for a registered table
// memory read in the back end. Register at a free port walks the valid marks
// one port per cycle; with a full table it answers without a walk. Results
// are registered and appear in the cycle after the back end finishes.
// A stalled result holds the back end at the next transaction that produces
// a result; the queue keeps accepting until full, and item_stall rises only
// then.
// Reset clears the valid marks, parser state and allocation pointer at once:
// no clearing pass, the block is ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module port_demux_frame_receiver_core
    import pdfr_pkg::*;
#(
    parameter int PORTS = PORTS_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    q_head_t q_head;
    logic    q_pop;

    pdfr_front #(
        .PORTS (PORTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (q_pop),
        .head       (q_head)
    );

    pdfr_back #(
        .PORTS (PORTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // the back end never takes from an empty queue
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    // an empty queue must never refuse a transaction
    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !q_head.valid |-> !item_stall)
        else $error("input stalled with empty queue");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_PAYLOAD)
            |-> (result.status == STS_OK && result.message_length != 8'd0))
        else $error("payload result with bad status or length");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_STATUS)
            |-> (result.offset == 8'd0 && !result.last && result.message_length == 8'd0))
        else $error("status result carries frame fields");

endmodule

// ===== verif/port_demux_frame_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// port_demux_frame_receiver_core_tb
// Self-checking bench for the port demux frame receiver. A queue of pending
// transactions feeds a clocked driver; a clocked monitor tracks the listener
// table and frame parser on every accepted transaction and checks each result
// field by field. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module port_demux_frame_receiver_core_tb;
    import pdfr_pkg::*;

    localparam int NPORTS         = PORTS_DEFAULT;
    localparam int TOTAL_ITEMS    = 1500;
    localparam int TAIL_ITEMS     = 200;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTS     = 40;
    localparam int RW             = $bits(result_t);

    typedef struct packed {
        item_t it;
        logic  drain;
        logic  hold;
    } pend_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    port_demux_frame_receiver_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // stimulus side
    pend_t pending_items[$];
    int    n_items;
    pend_t nxt;
    int    gap_left;
    int    gap_pct;
    int    nogap_left;
    int    n_loads;
    logic  draining;
    logic  stim_done = 1'b0;
    logic  tail = 1'b0;
    int    hold_seq = 0;

    // receiver side
    int    hold_seen;
    int    hold_left;
    int    stall_left;
    int    stall_pct;
    int    stall_cyc;

    // tracked block state
    logic       lst_valid [NPORTS];
    logic       lst_once  [NPORTS];
    logic [7:0] lst_cap   [NPORTS];
    logic [2:0] ph;
    logic [7:0] fr_port;
    logic [7:0] fr_cap;
    logic [7:0] left;
    logic [7:0] offs;
    logic [7:0] alloc_ptr;
    result_t    awaited_results[$];
    result_t    want;
    int         outstanding = 0;
    int         n_checked;
    int         n_mismatch = 0;
    int         quiet = 0;
    int         k;

    function automatic int pick_pct();
        case ($urandom_range(0, 4))
            0, 1:    return 0;
            2:       return 10;
            3:       return 30;
            default: return 60;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // expected behaviour
    // ------------------------------------------------------------------
    task automatic track_receiver(input item_t it);
        result_t    r;
        logic       hit;
        logic       found;
        logic [7:0] b;
        int         p;
        int         i;
        r   = '0;
        hit = 1'b0;
        b   = it.data_byte;
        case (it.command)
            CMD_STREAM:
                case (ph)
                    PH_PORT:
                    begin
                        fr_port = b;
                        if (int'(b) < NPORTS && lst_valid[b])
                        begin
                            fr_cap = lst_cap[b];
                            if (lst_once[b])
                            begin
                                lst_valid[b] = 1'b0;
                                lst_once[b]  = 1'b0;
                                lst_cap[b]   = '0;
                            end
                            ph = PH_LEN;
                        end
                        else
                            ph = PH_LEN_SKIP;
                    end
                    PH_LEN:
                    begin
                        if (b == 0 || b > fr_cap)
                        begin
                            ph                 = PH_HUNT;
                            hit                = 1'b1;
                            r.result_kind      = KIND_DONE;
                            r.port_out         = fr_port;
                            r.message_length   = b;
                        end
                        else
                        begin
                            left = b;
                            offs = '0;
                            ph   = PH_PAYLOAD;
                        end
                    end
                    PH_LEN_SKIP:
                    begin
                        left = b;
                        ph   = (b == 0) ? PH_HUNT : PH_SKIP;
                    end
                    PH_PAYLOAD:
                    begin
                        hit              = 1'b1;
                        r.result_kind    = KIND_PAYLOAD;
                        r.port_out       = fr_port;
                        r.offset         = offs;
                        r.payload_byte   = b;
                        r.message_length = offs + left;
                        r.last           = (left <= 1);
                        offs             = offs + 8'd1;
                        left             = left - 8'd1;
                        if (left == 0)
                            ph = PH_HUNT;
                    end
                    PH_SKIP:
                    begin
                        left = left - 8'd1;
                        if (left == 0)
                            ph = PH_HUNT;
                    end
                    default:
                        ph = (b == HEADER_BYTE) ? PH_PORT : PH_HUNT;
                endcase
            CMD_REG_AT:
            begin
                hit        = 1'b1;
                r.port_out = it.port;
                if (int'(it.port) >= NPORTS)
                    r.status = STS_FULL;
                else if (lst_valid[it.port])
                    r.status = STS_OCCUPIED;
                else
                begin
                    lst_valid[it.port] = 1'b1;
                    lst_once[it.port]  = it.one_shot;
                    lst_cap[it.port]   = it.capacity;
                    r.status           = STS_OK;
                end
            end
            CMD_REG_FREE:
            begin
                hit   = 1'b1;
                found = 1'b0;
                for (i = 0; i < NPORTS && !found; i++)
                begin
                    p = (int'(alloc_ptr) + i) % NPORTS;
                    if (!lst_valid[p])
                    begin
                        found        = 1'b1;
                        alloc_ptr    = p[7:0];
                        lst_valid[p] = 1'b1;
                        lst_once[p]  = it.one_shot;
                        lst_cap[p]   = it.capacity;
                    end
                end
                r.status   = found ? STS_OK : STS_FULL;
                r.port_out = alloc_ptr;
            end
            default:
            begin
                hit        = 1'b1;
                r.port_out = it.port;
                if (int'(it.port) < NPORTS && lst_valid[it.port])
                begin
                    lst_valid[it.port] = 1'b0;
                    lst_once[it.port]  = 1'b0;
                    lst_cap[it.port]   = '0;
                    r.status           = STS_OK;
                end
                else
                    r.status = STS_IDLE;
            end
        endcase
        if (hit)
            awaited_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [RW-1:0] got,
                                   input logic [RW-1:0] exp_val);
        n_mismatch++;
        if (n_mismatch <= MAX_PRINTS)
            $display("result %0d: %s got %0h, expected %0h", n_checked, what, got, exp_val);
    endtask

    task automatic compare_result(input result_t got, input result_t exp_r);
        if (got.result_kind !== exp_r.result_kind)
            report_mismatch("result_kind", RW'(got.result_kind), RW'(exp_r.result_kind));
        if (got.status !== exp_r.status)
            report_mismatch("status", RW'(got.status), RW'(exp_r.status));
        if (got.port_out !== exp_r.port_out)
            report_mismatch("port_out", RW'(got.port_out), RW'(exp_r.port_out));
        if (got.offset !== exp_r.offset)
            report_mismatch("offset", RW'(got.offset), RW'(exp_r.offset));
        if (got.payload_byte !== exp_r.payload_byte)
            report_mismatch("payload_byte", RW'(got.payload_byte),
                            RW'(exp_r.payload_byte));
        if (got.message_length !== exp_r.message_length)
            report_mismatch("message_length", RW'(got.message_length),
                            RW'(exp_r.message_length));
        if (got.last !== exp_r.last)
            report_mismatch("last", RW'(got.last), RW'(exp_r.last));
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input item_t it);
        pend_t e;
        e.it    = it;
        e.drain = 1'b0;
        e.hold  = 1'b0;
        pending_items.push_back(e);
        n_items++;
    endtask

    task automatic push_marker(input logic drain_m, input logic hold_m);
        pend_t e;
        e.it    = '0;
        e.drain = drain_m;
        e.hold  = hold_m;
        pending_items.push_back(e);
    endtask

    task automatic send_byte(input logic [7:0] b);
        item_t it;
        it           = item_t'($urandom);
        it.command   = CMD_STREAM;
        it.data_byte = b;
        push_item(it);
    endtask

    task automatic send_cmd(input logic [1:0] code, input logic [7:0] p,
                            input logic [7:0] cap, input logic once);
        item_t it;
        it          = item_t'($urandom);
        it.command  = code;
        it.port     = p;
        it.capacity = cap;
        it.one_shot = once;
        push_item(it);
    endtask

    function automatic logic [7:0] pick_port();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 8'($urandom_range(0, 7));
        else if (sel < 7)
            return 8'($urandom_range(248, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_cap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return 8'($urandom_range(0, 10));
        else if (sel == 6)
            return 8'd0;
        else if (sel == 7)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 8'($urandom_range(0, 12));
        else if (sel < 93)
            return 8'($urandom_range(0, 40));
        else if (sel < 99)
            return 8'($urandom_range(0, 255));
        return 8'd255;
    endfunction

    task automatic send_table_cmd();
        case ($urandom_range(0, 2))
            0:       send_cmd(CMD_REG_AT, pick_port(), pick_cap(), 1'($urandom_range(0, 1)));
            1:       send_cmd(CMD_REG_FREE, 8'($urandom), pick_cap(),
                              1'($urandom_range(0, 1)));
            default: send_cmd(CMD_RELEASE, pick_port(), 8'($urandom),
                              1'($urandom_range(0, 1)));
        endcase
    endtask

    // mixed: table commands land inside the frame
    task automatic send_frame(input logic [7:0] p, input logic [7:0] len, input logic mixed);
        int i;
        send_byte(HEADER_BYTE);
        send_byte(p);
        if (mixed)
            send_table_cmd();
        send_byte(len);
        for (i = 0; i < len; i++)
        begin
            send_byte(8'($urandom));
            if (mixed && $urandom_range(0, 3) == 0)
                send_table_cmd();
        end
    endtask

    task automatic random_episode();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 48)
            send_frame(pick_port(), pick_len(), 1'b0);
        else if (sel < 60)
            send_cmd(CMD_REG_AT, pick_port(), pick_cap(), 1'($urandom_range(0, 1)));
        else if (sel < 67)
            send_cmd(CMD_REG_FREE, 8'($urandom), pick_cap(), 1'($urandom_range(0, 1)));
        else if (sel < 78)
            send_cmd(CMD_RELEASE, pick_port(), 8'($urandom), 1'($urandom_range(0, 1)));
        else if (sel < 86)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        else if (sel < 94)
            send_frame(pick_port(), pick_len(), 1'b1);
        else
        begin
            // frame cut short, then noise
            send_byte(HEADER_BYTE);
            if ($urandom_range(0, 1))
                send_byte(pick_port());
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
        end
    endtask

    // fill every port through the free search, hit the full case, then empty it
    task automatic fill_and_empty();
        int p;
        repeat (NPORTS + 2)
            send_cmd(CMD_REG_FREE, 8'($urandom), pick_cap(), 1'($urandom_range(0, 1)));
        send_cmd(CMD_REG_AT, 8'($urandom), pick_cap(), 1'($urandom_range(0, 1)));
        repeat (6) send_frame(pick_port(), pick_len(), 1'b0);
        for (p = 0; p < NPORTS; p++)
            send_cmd(CMD_RELEASE, p[7:0], 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            hold_seq   <= 0;
            stim_done  <= 1'b0;
            tail       <= 1'b0;
            gap_left   = 0;
            gap_pct    = 20;
            nogap_left = 0;
            n_loads    = 0;
            draining   = 1'b0;
        end
        else
        begin
            if (!item_valid || !item_stall)
            begin
                if (draining)
                begin
                    item_valid <= 1'b0;
                    if (outstanding == 0)
                        draining = 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    item_valid <= 1'b0;
                else
                begin
                    nxt = pending_items.pop_front();
                    if (nxt.drain)
                    begin
                        draining = 1'b1;
                        item_valid <= 1'b0;
                    end
                    else if (nxt.hold)
                    begin
                        hold_seq   <= hold_seq + 1;
                        nogap_left = 64;
                        item_valid <= 1'b0;
                    end
                    else
                    begin
                        item       <= nxt.it;
                        item_valid <= 1'b1;
                        n_loads++;
                        if (n_loads % 100 == 0)
                            gap_pct = pick_pct();
                        if (nogap_left > 0)
                            nogap_left--;
                        else if (!tail && $urandom_range(0, 99) < gap_pct)
                            gap_left = $urandom_range(1, 18);
                    end
                end
            end
            tail      <= (pending_items.size() < TAIL_ITEMS);
            stim_done <= (pending_items.size() == 0) && !draining;
        end
    end

    // ------------------------------------------------------------------
    // result stall
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_seen    = 0;
            hold_left    = 0;
            stall_left   = 0;
            stall_pct    = 20;
            stall_cyc    = 0;
        end
        else
        begin
            stall_cyc++;
            if (stall_cyc % 128 == 0)
                stall_pct = pick_pct();
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (!tail && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 17);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: track inputs, then check results
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < NPORTS; k++)
            begin
                lst_valid[k] = 1'b0;
                lst_once[k]  = 1'b0;
                lst_cap[k]   = '0;
            end
            ph        = PH_HUNT;
            fr_port   = '0;
            fr_cap    = '0;
            left      = '0;
            offs      = '0;
            alloc_ptr = '0;
            n_checked = 0;
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                track_receiver(item);
            if (result_valid && !result_stall)
            begin
                n_checked++;
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected result", result, '0);
                else
                begin
                    want = awaited_results.pop_front();
                    compare_result(result, want);
                end
            end
            outstanding <= awaited_results.size();
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic hold1_done;
        logic hold2_done;
        logic fill_done;
        hold1_done = 1'b0;
        hold2_done = 1'b0;
        fill_done  = 1'b0;
        n_items    = 0;

        // directed
        send_cmd(CMD_RELEASE, 8'd5, 8'd0, 1'b0);
        send_cmd(CMD_REG_AT, 8'd0, 8'd255, 1'b0);
        send_cmd(CMD_REG_AT, 8'd0, 8'd17, 1'b1);
        send_cmd(CMD_REG_AT, 8'd255, 8'd0, 1'b1);
        send_cmd(CMD_REG_FREE, 8'd200, 8'd3, 1'b1);
        // port 0 released mid-frame: the frame keeps its listener
        send_byte(HEADER_BYTE);
        send_byte(8'd0);
        send_byte(8'd2);
        send_cmd(CMD_RELEASE, 8'd0, 8'd0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        // zero length to a one-shot listener with no capacity
        send_byte(HEADER_BYTE);
        send_byte(8'd255);
        send_byte(8'd0);
        // length over capacity
        send_byte(HEADER_BYTE);
        send_byte(8'd1);
        send_byte(8'd4);
        // unlistened port, skipped payload looks like a header
        send_byte(HEADER_BYTE);
        send_byte(8'd9);
        send_byte(8'd1);
        send_byte(HEADER_BYTE);
        // unlistened port, zero length
        send_byte(HEADER_BYTE);
        send_byte(8'd9);
        send_byte(8'd0);
        push_marker(1'b1, 1'b0);

        while (n_items < TOTAL_ITEMS)
        begin
            if (!hold1_done && n_items >= 300)
            begin
                push_marker(1'b0, 1'b1);
                hold1_done = 1'b1;
            end
            if (!fill_done && n_items >= 700)
            begin
                push_marker(1'b1, 1'b0);
                fill_and_empty();
                fill_done = 1'b1;
            end
            if (!hold2_done && n_items >= 1200)
            begin
                push_marker(1'b0, 1'b1);
                hold2_done = 1'b1;
            end
            random_episode();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (!stim_done || item_valid || outstanding != 0);
        repeat (NPORTS + 32) @(posedge clk);

        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
